### design/sha1_pkg.sv
// sha1_pkg: shared constants, round helpers and the schedule control struct
// for the sha-1 hash engine; depends on nothing
package sha1_pkg;

  localparam int ChainWords = 5;
  localparam logic [6:0] LastRound = 7'd79;
  localparam logic [5:0] LastByte = 6'd63;
  localparam logic [5:0] LengthStart = 6'd56;
  localparam logic [7:0] PadMarker = 8'h80;
  localparam logic [2:0] LastWordIdx = 3'd4;

  typedef struct packed {
    logic       push;
    logic       word_end;
    logic [7:0] byte_val;
    logic       step;
    logic       expand;
  } sched_ctrl_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] val;
    case (idx)
      3'd0: val = 32'h67452301;
      3'd1: val = 32'hefcdab89;
      3'd2: val = 32'h98badcfe;
      3'd3: val = 32'h10325476;
      3'd4: val = 32'hc3d2e1f0;
      default: val = 32'h0;
    endcase
    return val;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    logic [31:0] val;
    if (rnd < 7'd20) begin
      val = 32'h5a827999;
    end else if (rnd < 7'd40) begin
      val = 32'h6ed9eba1;
    end else if (rnd < 7'd60) begin
      val = 32'h8f1bbcdc;
    end else begin
      val = 32'hca62c1d6;
    end
    return val;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] val;
    if (rnd < 7'd20) begin
      val = (b & c) | (~b & d);
    end else if (rnd >= 7'd40 && rnd < 7'd60) begin
      val = (b & c) | (b & d) | (c & d);
    end else begin
      val = b ^ c ^ d;
    end
    return val;
  endfunction

endpackage

### design/sha1_sched.sv
// sha1_sched: byte packing and the rolling sixteen-word message schedule
// depends on sha1_pkg
module sha1_sched (
  input  logic                  clk,
  input  sha1_pkg::sched_ctrl_t ctrl,
  output logic [31:0]           w
);

  logic [31:0] line [16];
  logic [23:0] acc;
  logic [31:0] mix;

  assign mix = line[13] ^ line[8] ^ line[2] ^ line[0];
  assign w = ctrl.expand ? {mix[30:0], mix[31]} : line[0];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      acc <= {acc[15:0], ctrl.byte_val};
      if (ctrl.word_end) begin
        for (int k = 0; k < 15; k++) begin
          line[k] <= line[k + 1];
        end
        line[15] <= {acc, ctrl.byte_val};
      end
    end else if (ctrl.step) begin
      for (int k = 0; k < 15; k++) begin
        line[k] <= line[k + 1];
      end
      line[15] <= w;
    end
  end

endmodule

### design/sha1_hash_engine.sv
// sha1_hash_engine: byte-serial sha-1 with padding and five-beat digest output
// depends on sha1_pkg and sha1_sched
//
//   channel  handshake                   payload
//   data     data_valid / data_ready     data_byte, byte_present, end_of_message
//   digest   digest_valid / digest_ready digest_word, word_number, last_word
//
// the 64th byte of a block starts 80 rounds and a fold,
// one round per cycle through a single round adder.
// a final beat adds the padding bytes plus 80 rounds and a fold per padded
// block, then five digest beats; data_ready is low from the final beat until word 4 leaves.
// rst is synchronous and restores the initial chaining value; a stalled digest
// beat simply holds.
module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        end_of_message,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        last_word
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ROUND = 5'b00010,
    S_FOLD  = 5'b00100,
    S_PAD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [31:0] chain [sha1_pkg::ChainWords];
  logic [31:0] a, b, c, d, e;
  logic [63:0] bit_len;
  logic [6:0]  round_cnt;
  logic [5:0]  byte_cnt;
  logic [2:0]  out_idx;
  logic        pad_active, marker_sent, len_phase;

  logic        absorb_en;
  logic [7:0]  absorb_byte;
  logic        len_sel;
  logic [7:0]  len_byte;
  logic [7:0]  pad_byte;
  logic [31:0] wt;
  logic [31:0] tmp;
  logic        in_fire, out_fire;
  sha1_pkg::sched_ctrl_t sched_ctrl;

  assign data_ready   = (state == S_IDLE);
  assign in_fire      = data_valid && data_ready;
  assign digest_valid = (state == S_OUT);
  assign out_fire     = digest_valid && digest_ready;
  assign digest_word  = chain[out_idx];
  assign word_number  = out_idx;
  assign last_word    = (out_idx == sha1_pkg::LastWordIdx);

  assign len_sel  = len_phase || (marker_sent && byte_cnt == sha1_pkg::LengthStart);
  assign len_byte = 8'(bit_len >> {~byte_cnt[2:0], 3'b000});
  assign pad_byte = !marker_sent ? sha1_pkg::PadMarker : (len_sel ? len_byte : 8'h00);

  always_comb begin
    absorb_en   = 1'b0;
    absorb_byte = pad_byte;
    if (state == S_IDLE) begin
      absorb_en   = in_fire && byte_present;
      absorb_byte = data_byte;
    end else if (state == S_PAD) begin
      absorb_en   = 1'b1;
    end
  end

  assign sched_ctrl.push     = absorb_en;
  assign sched_ctrl.word_end = (byte_cnt[1:0] == 2'b11);
  assign sched_ctrl.byte_val = absorb_byte;
  assign sched_ctrl.step     = (state == S_ROUND);
  assign sched_ctrl.expand   = (round_cnt >= 7'd16);

  sha1_sched u_sched (
    .clk  (clk),
    .ctrl (sched_ctrl),
    .w    (wt)
  );

  assign tmp = {a[26:0], a[31:27]} + sha1_pkg::round_f(round_cnt, b, c, d) + e
             + sha1_pkg::round_k(round_cnt) + wt;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (byte_present && byte_cnt == sha1_pkg::LastByte) begin
            state_next = S_ROUND;
          end else if (end_of_message) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (byte_cnt == sha1_pkg::LastByte) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        if (round_cnt == sha1_pkg::LastRound) begin
          state_next = S_FOLD;
        end
      end
      S_FOLD: begin
        if (len_phase) begin
          state_next = S_OUT;
        end else if (pad_active) begin
          state_next = S_PAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_fire && last_word) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      bit_len     <= '0;
      round_cnt   <= '0;
      byte_cnt    <= '0;
      out_idx     <= '0;
      pad_active  <= 1'b0;
      marker_sent <= 1'b0;
      len_phase   <= 1'b0;
      for (int i = 0; i < sha1_pkg::ChainWords; i++) begin
        chain[i] <= sha1_pkg::init_word(3'(i));
      end
    end else begin
      state <= state_next;
      if (in_fire) begin
        pad_active <= end_of_message;
        if (byte_present) begin
          bit_len <= bit_len + 64'd8;
        end
      end
      if (state == S_PAD) begin
        marker_sent <= 1'b1;
        len_phase   <= len_sel;
      end
      if (absorb_en) begin
        byte_cnt <= byte_cnt + 6'd1;
        if (byte_cnt == sha1_pkg::LastByte) begin
          round_cnt <= '0;
        end
      end
      if (state == S_ROUND) begin
        round_cnt <= round_cnt + 7'd1;
      end
      if (state == S_FOLD) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (out_fire) begin
        if (last_word) begin
          out_idx     <= '0;
          bit_len     <= '0;
          byte_cnt    <= '0;
          pad_active  <= 1'b0;
          marker_sent <= 1'b0;
          len_phase   <= 1'b0;
          for (int i = 0; i < sha1_pkg::ChainWords; i++) begin
            chain[i] <= sha1_pkg::init_word(3'(i));
          end
        end else begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    if (absorb_en && byte_cnt == sha1_pkg::LastByte) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (state == S_ROUND) begin
      a <= tmp;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> !data_ready)
    else $error("input taken while digest beats pending");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && round_cnt == sha1_pkg::LastRound) |=> (state == S_FOLD))
    else $error("compression did not fold after last round");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND) |-> (round_cnt <= sha1_pkg::LastRound))
    else $error("round counter overran");

  assert property (@(posedge clk) disable iff (rst)
    (out_fire && last_word) |=> (state == S_IDLE && byte_cnt == 6'd0 && bit_len == 64'd0))
    else $error("message state not cleared after digest");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// testbench for sha1_hash_engine: byte beats in, five-beat digests out, each digest
// compared against a sha-1 predictor kept alongside; needs only the design sources
module testbench;

  localparam int ClkPeriod = 12;
  localparam int HoldCycles = 300;
  localparam int SettleCycles = 200;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LengthOffset = 6'd56;
  localparam logic [31:0] RoundK0 = 32'h5a827999;
  localparam logic [31:0] RoundK1 = 32'h6ed9eba1;
  localparam logic [31:0] RoundK2 = 32'h8f1bbcdc;
  localparam logic [31:0] RoundK3 = 32'hca62c1d6;
  localparam logic [31:0] StartChain [5] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  position;
    logic        final_word;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        digest_valid;
  logic        digest_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        last_word;

  // predictor state
  logic [31:0] chain_state [5];
  logic [31:0] msg_sched [16];
  logic [63:0] msg_bits;
  logic [5:0]  block_fill;
  digest_beat_t digest_due [$];

  int   mismatches = 0;
  logic quiet_phase = 1'b0;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   hold_left = 0;

  sha1_hash_engine dut (
    .clk            (clk),
    .rst            (rst),
    .data_valid     (data_valid),
    .data_ready     (data_ready),
    .data_byte      (data_byte),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .digest_valid   (digest_valid),
    .digest_ready   (digest_ready),
    .digest_word    (digest_word),
    .word_number    (word_number),
    .last_word      (last_word)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  function automatic logic [31:0] rotate_left(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic restart_hash;
    for (int i = 0; i < 5; i++) chain_state[i] = StartChain[i];
    msg_bits = '0;
    block_fill = '0;
  endtask

  task automatic compress_block;
    logic [31:0] a, b, c, d, e, f, k, w, t;
    int idx;
    a = chain_state[0];
    b = chain_state[1];
    c = chain_state[2];
    d = chain_state[3];
    e = chain_state[4];
    for (int r = 0; r < 80; r++) begin
      idx = r % 16;
      if (r >= 16) begin
        w = msg_sched[(idx + 13) % 16] ^ msg_sched[(idx + 8) % 16]
          ^ msg_sched[(idx + 2) % 16] ^ msg_sched[idx];
        msg_sched[idx] = rotate_left(w, 1);
      end
      w = msg_sched[idx];
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RoundK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RoundK1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RoundK2;
      end else begin
        f = b ^ c ^ d;
        k = RoundK3;
      end
      t = rotate_left(a, 5) + f + e + k + w;
      e = d;
      d = c;
      c = rotate_left(b, 30);
      b = a;
      a = t;
    end
    chain_state[0] += a;
    chain_state[1] += b;
    chain_state[2] += c;
    chain_state[3] += d;
    chain_state[4] += e;
  endtask

  task automatic absorb_byte(input logic [7:0] val);
    int idx;
    int shift;
    idx = int'(block_fill[5:2]);
    shift = (3 - block_fill[1:0]) * 8;
    if (block_fill[1:0] == 2'd0) msg_sched[idx] = '0;
    msg_sched[idx] |= {24'h0, val} << shift;
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0) compress_block();
  endtask

  // folds one accepted beat into the hash and queues the digest when it closes
  task automatic absorb_item(input logic [7:0] val, input logic present, input logic eom);
    logic [63:0] len;
    digest_beat_t beat;
    if (present) begin
      absorb_byte(val);
      msg_bits += 64'd8;
    end
    if (eom) begin
      len = msg_bits;
      absorb_byte(PadByte);
      while (block_fill != LengthOffset) absorb_byte(8'h00);
      for (int k = 7; k >= 0; k--) absorb_byte(len[8 * k +: 8]);
      for (int k = 0; k < 5; k++) begin
        beat.word = chain_state[k];
        beat.position = 3'(k);
        beat.final_word = (k == 4);
        digest_due = {digest_due, beat};
      end
      restart_hash();
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < 40) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_item(input logic [7:0] val, input logic present, input logic eom);
    int gap;
    gap = 0;
    if (!quiet_phase && $urandom_range(99) < 15) gap = $urandom_range(1, 2);
    if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= val;
    byte_present <= present;
    end_of_message <= eom;
    do @(posedge clk); while (!data_ready);
    absorb_item(val, present, eom);
  endtask

  task automatic wait_drained;
    data_valid <= 1'b0;
    while (digest_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // digest side: random stalls, long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      digest_ready <= 1'b0;
    end else if (hold_left > 0) begin
      digest_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_served + 1;
      hold_left <= HoldCycles;
      digest_ready <= 1'b0;
    end else if (quiet_phase) begin
      digest_ready <= 1'b1;
    end else begin
      digest_ready <= ($urandom_range(99) >= 15);
    end
  end

  always @(posedge clk) begin
    digest_beat_t due;
    if (!rst && digest_valid && digest_ready) begin
      if (digest_due.size() == 0) begin
        report_mismatch($sformatf("digest beat %h with nothing expected", digest_word));
      end else begin
        due = digest_due.pop_front();
        if (digest_word !== due.word)
          report_mismatch($sformatf("word %0d: got %h, want %h",
                                    due.position, digest_word, due.word));
        if (word_number !== due.position)
          report_mismatch($sformatf("word_number: got %0d, want %0d",
                                    word_number, due.position));
        if (last_word !== due.final_word)
          report_mismatch($sformatf("last_word on word %0d: got %b, want %b",
                                    due.position, last_word, due.final_word));
      end
    end
  end

  task automatic test_empty_message;
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_short_messages;
    // "abc", final beat carries a byte
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // single zero byte then empty final beat, idle beat in between
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure;
    hold_requests <= hold_requests + 1;
    for (int m = 0; m < 3; m++) begin
      send_item(8'($urandom_range(255)), 1'b1, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, 1'b1);
    end
    wait_drained();
  endtask

  task automatic test_random_messages;
    int sent;
    int msgs;
    int len;
    int pick;
    logic with_byte;
    sent = 0;
    msgs = 0;
    while (sent < 420 || msgs < 8) begin
      quiet_phase <= (msgs >= 4 && msgs < 7);
      pick = $urandom_range(99);
      if (pick < 45) begin
        len = $urandom_range(0, 10);
      end else if (pick < 75) begin
        case ($urandom_range(0, 9))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          7: len = 120;
          8: len = 127;
          default: len = 128;
        endcase
      end else begin
        len = $urandom_range(11, 130);
      end
      with_byte = (len > 0) && $urandom_range(1);
      for (int n = 0; n < len - with_byte; n++) begin
        if ($urandom_range(99) < 8) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
        send_item(8'($urandom_range(255)), 1'b1, 1'b0);
        sent++;
      end
      send_item(8'($urandom_range(255)), with_byte, 1'b1);
      sent++;
      msgs++;
      if ($urandom_range(99) < 10) wait_drained();
    end
    quiet_phase <= 1'b0;
    wait_drained();
  endtask

  initial begin
    restart_hash();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_message();
    test_short_messages();
    test_backpressure();
    test_random_messages();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(ClkPeriod * 3000000);
    $display("tb: failure");
    $finish;
  end

endmodule
